@@ rtl/assert_macros.svh @@
// assertion macros shared by the radar cone gate rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond in a cycle implies expr in the same cycle
`define RCG_ASSERT_IMPLY(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed");

// cond in a cycle implies expr later, after the delay n given to ##
`define RCG_ASSERT_DELAY(label, clk, rst, cond, n, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> ##n (expr)) \
      else $error("assertion failed");

`endif

@@ rtl/rcg_pkg.sv @@
// types, constants and the arctangent table of the radar cone gate
package rcg_pkg;

   localparam int COORD_W     = 29;
   localparam int DIFF_W      = 30;
   localparam int SQ_W        = 60;
   localparam int LIM_SQ_W    = 58;
   localparam int CW          = 34;
   localparam int ANGLE_W     = 32;
   localparam int BEARING_W   = 16;
   localparam int TAG_W       = 10;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 29;

   localparam logic [ANGLE_W-1:0]   HALF_TURN         = 32'h8000_0000;
   localparam logic [ANGLE_W-1:0]   ROUND_HALF        = 32'h0000_8000;
   localparam logic [BEARING_W-1:0] HALF_ANGLE_RESET  = 16'd8192;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CENTER_LAT  = 3'd0,
      CSR_CENTER_LON  = 3'd1,
      CSR_HEADING     = 3'd2,
      CSR_HALF_ANGLE  = 3'd3,
      CSR_RANGE_LIMIT = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic             last;
   } rcg_side_type;

   typedef struct packed {
      logic               valid;
      logic               zero;
      logic [ANGLE_W-1:0] angle;
      rcg_side_type       side;
   } rcg_cordic_type;

   // atan(2^-i) as a 32-bit binary angle, rounded to nearest
   function automatic logic [ANGLE_W-1:0] atan_angle(input int idx);
      logic [ANGLE_W-1:0] a;
      case (idx)
         0:       a = 32'd536870912;
         1:       a = 32'd316933406;
         2:       a = 32'd167458907;
         3:       a = 32'd85004756;
         4:       a = 32'd42667331;
         5:       a = 32'd21354465;
         6:       a = 32'd10679838;
         7:       a = 32'd5340245;
         8:       a = 32'd2670163;
         9:       a = 32'd1335087;
         10:      a = 32'd667544;
         11:      a = 32'd333772;
         12:      a = 32'd166886;
         13:      a = 32'd83443;
         14:      a = 32'd41722;
         15:      a = 32'd20861;
         16:      a = 32'd10430;
         17:      a = 32'd5215;
         18:      a = 32'd2608;
         19:      a = 32'd1304;
         20:      a = 32'd652;
         21:      a = 32'd326;
         22:      a = 32'd163;
         23:      a = 32'd81;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

@@ rtl/rcg_cordic.sv @@
// pipelined vectoring cordic: one rotation step per register stage
module rcg_cordic #(
   parameter int STEPS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   input  logic signed [rcg_pkg::DIFF_W-1:0]     in_dlat,
   input  logic signed [rcg_pkg::DIFF_W-1:0]     in_dlon,
   input  rcg_pkg::rcg_side_type                 in_side,
   output rcg_pkg::rcg_cordic_type               result
);
   import rcg_pkg::*;

   logic signed [CW-1:0] x_ff [0:STEPS-1];
   logic signed [CW-1:0] y_ff [0:STEPS-1];
   logic signed [CW-1:0] x_in [0:STEPS-1];
   logic signed [CW-1:0] y_in [0:STEPS-1];
   logic [ANGLE_W-1:0]   z_ff [0:STEPS];
   logic [ANGLE_W-1:0]   z_in [0:STEPS];
   logic                 valid_ff [0:STEPS];
   logic                 zero_ff [0:STEPS];
   rcg_side_type         side_ff [0:STEPS];

   always_comb begin
      logic up;
      // left half plane: turn by half a turn first
      if (in_dlat[DIFF_W-1]) begin
         x_in[0] = -CW'(in_dlat);
         y_in[0] = -CW'(in_dlon);
         z_in[0] = HALF_TURN;
      end else begin
         x_in[0] = CW'(in_dlat);
         y_in[0] = CW'(in_dlon);
         z_in[0] = '0;
      end
      for (int k = 0; k < STEPS; k++) begin
         up = !y_ff[k][CW-1] && (y_ff[k] != '0);
         z_in[k+1] = up ? z_ff[k] + atan_angle(k) : z_ff[k] - atan_angle(k);
         if (k < STEPS - 1) begin
            x_in[k+1] = up ? x_ff[k] + (y_ff[k] >>> k) : x_ff[k] - (y_ff[k] >>> k);
            y_in[k+1] = up ? y_ff[k] - (x_ff[k] >>> k) : y_ff[k] + (x_ff[k] >>> k);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= STEPS; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= in_valid;
         for (int k = 0; k < STEPS; k++) begin
            valid_ff[k+1] <= valid_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      zero_ff[0] <= (in_dlat == '0) && (in_dlon == '0);
      side_ff[0] <= in_side;
      for (int k = 0; k < STEPS; k++) begin
         x_ff[k] <= x_in[k];
         y_ff[k] <= y_in[k];
      end
      for (int k = 0; k <= STEPS; k++) begin
         z_ff[k] <= z_in[k];
      end
      for (int k = 0; k < STEPS; k++) begin
         zero_ff[k+1] <= zero_ff[k];
         side_ff[k+1] <= side_ff[k];
      end
   end

   assign result.valid = valid_ff[STEPS];
   assign result.zero  = zero_ff[STEPS];
   assign result.angle = z_ff[STEPS];
   assign result.side  = side_ff[STEPS];

endmodule

@@ rtl/rcg_range.sv @@
// squared distance against squared range limit, delayed to match the cordic
module rcg_range #(
   parameter int LAT = 17
) (
   input  logic                              clock,
   input  logic signed [rcg_pkg::DIFF_W-1:0] dlat,
   input  logic signed [rcg_pkg::DIFF_W-1:0] dlon,
   input  logic [rcg_pkg::COORD_W-1:0]       range_limit,
   output logic                              range_ok
);
   import rcg_pkg::*;

   logic [DIFF_W-1:0]   abs_lat;
   logic [DIFF_W-1:0]   abs_lon;
   logic [SQ_W-1:0]     sq_lat_ff;
   logic [SQ_W-1:0]     sq_lon_ff;
   logic [LIM_SQ_W-1:0] lim_sq_ff;
   logic [SQ_W:0]       dist_sq;
   logic                ok_ff [0:LAT-2];

   assign abs_lat = dlat[DIFF_W-1] ? DIFF_W'(-dlat) : DIFF_W'(dlat);
   assign abs_lon = dlon[DIFF_W-1] ? DIFF_W'(-dlon) : DIFF_W'(dlon);
   assign dist_sq = {1'b0, sq_lat_ff} + {1'b0, sq_lon_ff};

   always_ff @(posedge clock) begin
      sq_lat_ff <= SQ_W'(abs_lat) * SQ_W'(abs_lat);
      sq_lon_ff <= SQ_W'(abs_lon) * SQ_W'(abs_lon);
      lim_sq_ff <= LIM_SQ_W'(range_limit) * LIM_SQ_W'(range_limit);
      ok_ff[0]  <= dist_sq <= (SQ_W+1)'(lim_sq_ff);
      for (int k = 0; k < LAT - 2; k++) begin
         ok_ff[k+1] <= ok_ff[k];
      end
   end

   assign range_ok = ok_ff[LAT-2];

endmodule

@@ rtl/radar_cone_gate.sv @@
// radar cone gate: range and bearing sector test, one target per cycle
// throughput: one target per cycle, set by the one-step-per-stage cordic pipeline
// busy is high only during reset; results carry a one-cycle rsp_valid strobe
// reset is synchronous: pipeline valid bits clear, configuration registers return to their defaults
module radar_cone_gate #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic signed [rcg_pkg::COORD_W-1:0]     req_target_lat,
   input  logic signed [rcg_pkg::COORD_W-1:0]     req_target_lon,
   input  logic [rcg_pkg::TAG_W-1:0]              req_target_tag,
   input  logic                                   req_last_target,
   output logic                                   rsp_valid,
   output logic                                   rsp_in_cone,
   output logic [rcg_pkg::BEARING_W-1:0]          rsp_bearing,
   output logic [rcg_pkg::TAG_W-1:0]              rsp_out_tag,
   output logic                                   rsp_out_last,
   input  logic                                   csr_we,
   input  logic [rcg_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [rcg_pkg::CSR_DATA_W-1:0]         csr_wdata
);
   import rcg_pkg::*;
   `include "assert_macros.svh"

   localparam int LATENCY = CORDIC_STEPS + 3;

   logic signed [COORD_W-1:0] center_lat_ff;
   logic signed [COORD_W-1:0] center_lon_ff;
   logic [BEARING_W-1:0]      heading_ff;
   logic [BEARING_W-1:0]      half_angle_ff;
   logic [COORD_W-1:0]        range_limit_ff;

   logic                      in_valid_ff;
   logic signed [DIFF_W-1:0]  dlat_ff;
   logic signed [DIFF_W-1:0]  dlon_ff;
   rcg_side_type              side_ff;

   rcg_cordic_type            cordic;
   logic                      range_ok;

   logic [ANGLE_W-1:0]        rounded;
   logic [BEARING_W-1:0]      bearing_in;
   logic [BEARING_W-1:0]      left_bound;
   logic [BEARING_W-1:0]      right_bound;
   logic                      in_cone_in;

   logic                      rsp_valid_ff;
   logic                      rsp_in_cone_ff;
   logic [BEARING_W-1:0]      rsp_bearing_ff;
   logic [TAG_W-1:0]          rsp_out_tag_ff;
   logic                      rsp_out_last_ff;

   assign busy = reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_lat_ff  <= '0;
         center_lon_ff  <= '0;
         heading_ff     <= '0;
         half_angle_ff  <= HALF_ANGLE_RESET;
         range_limit_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CENTER_LAT:  center_lat_ff  <= csr_wdata;
            CSR_CENTER_LON:  center_lon_ff  <= csr_wdata;
            CSR_HEADING:     heading_ff     <= csr_wdata[BEARING_W-1:0];
            CSR_HALF_ANGLE:  half_angle_ff  <= csr_wdata[BEARING_W-1:0];
            CSR_RANGE_LIMIT: range_limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input stage: offsets from the radar centre
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      dlat_ff      <= DIFF_W'(req_target_lat) - DIFF_W'(center_lat_ff);
      dlon_ff      <= DIFF_W'(req_target_lon) - DIFF_W'(center_lon_ff);
      side_ff.tag  <= req_target_tag;
      side_ff.last <= req_last_target;
   end

   rcg_cordic #(
      .STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock    (clock),
      .reset    (reset),
      .in_valid (in_valid_ff),
      .in_dlat  (dlat_ff),
      .in_dlon  (dlon_ff),
      .in_side  (side_ff),
      .result   (cordic)
   );

   rcg_range #(
      .LAT (CORDIC_STEPS + 1)
   ) u_range (
      .clock       (clock),
      .dlat        (dlat_ff),
      .dlon        (dlon_ff),
      .range_limit (range_limit_ff),
      .range_ok    (range_ok)
   );

   // round the 32-bit angle to 16 bits and test it against the cone and the range limit
   always_comb begin
      rounded     = cordic.angle + ROUND_HALF;
      bearing_in  = cordic.zero ? '0 : rounded[ANGLE_W-1 -: BEARING_W];
      left_bound  = heading_ff - half_angle_ff;
      right_bound = heading_ff + half_angle_ff;
      if (left_bound <= right_bound) begin
         in_cone_in = (bearing_in >= left_bound) && (bearing_in <= right_bound);
      end else begin
         in_cone_in = (bearing_in >= left_bound) || (bearing_in <= right_bound);
      end
      in_cone_in = in_cone_in && range_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cordic.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_in_cone_ff  <= in_cone_in;
      rsp_bearing_ff  <= bearing_in;
      rsp_out_tag_ff  <= cordic.side.tag;
      rsp_out_last_ff <= cordic.side.last;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_in_cone  = rsp_in_cone_ff;
   assign rsp_bearing  = rsp_bearing_ff;
   assign rsp_out_tag  = rsp_out_tag_ff;
   assign rsp_out_last = rsp_out_last_ff;

   `RCG_ASSERT_DELAY(a_accept_gives_result, clock, reset, start && !busy, LATENCY, rsp_valid)
   `RCG_ASSERT_IMPLY(a_result_has_source, clock, reset, rsp_valid, $past(start && !busy, LATENCY))
   `RCG_ASSERT_DELAY(a_centre_bearing_zero, clock, reset, cordic.valid && cordic.zero, 1, rsp_bearing == '0)

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the radar cone gate: range and bearing sector test
module testbench;
   import rcg_pkg::*;

   localparam int CORDIC_STEPS = 16;
   localparam int LATENCY      = CORDIC_STEPS + 3;
   localparam int MAX_REPORTS  = 20;
   localparam int RANDOM_SETS  = 8;
   localparam int SET_ITEMS    = 250;
   localparam longint TIMEOUT  = 3_000_000;

   localparam logic [COORD_W-1:0] COORD_MIN = 29'h1000_0000;
   localparam logic [COORD_W-1:0] COORD_MAX = 29'h0FFF_FFFF;
   localparam logic [COORD_W-1:0] RANGE_MAX = 29'h1FFF_FFFF;

   typedef struct packed {
      logic                 in_cone;
      logic [BEARING_W-1:0] bearing;
      logic [TAG_W-1:0]     tag;
      logic                 last;
   } cone_verdict_type;

   class cone_scoreboard_type;
      logic signed [COORD_W-1:0] ctr_lat;
      logic signed [COORD_W-1:0] ctr_lon;
      logic [BEARING_W-1:0]      heading;
      logic [BEARING_W-1:0]      half_width;
      logic [COORD_W-1:0]        range_lim;
      logic [ANGLE_W-1:0]        atan_step [24];
      int                        step_count;
      cone_verdict_type          expected_q [$];
      int                        errors;
      int                        checked;
      int                        hits;

      function new();
         ctr_lat    = '0;
         ctr_lon    = '0;
         heading    = '0;
         half_width = 16'd8192;
         range_lim  = '0;
         atan_step  = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                        10679838, 5340245, 2670163, 1335087, 667544, 333772,
                        166886, 83443, 41722, 20861, 10430, 5215,
                        2608, 1304, 652, 326, 163, 81};
         step_count = (CORDIC_STEPS > 24) ? 24 : ((CORDIC_STEPS < 1) ? 1 : CORDIC_STEPS);
         errors     = 0;
         checked    = 0;
         hits       = 0;
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_CENTER_LAT:  ctr_lat    = data;
            CSR_CENTER_LON:  ctr_lon    = data;
            CSR_HEADING:     heading    = data[BEARING_W-1:0];
            CSR_HALF_ANGLE:  half_width = data[BEARING_W-1:0];
            CSR_RANGE_LIMIT: range_lim  = data;
            default: ;
         endcase
      endfunction

      function int outstanding();
         return expected_q.size();
      endfunction

      // bearing by vectoring cordic, then range and sector test
      function void note_target(logic signed [COORD_W-1:0] lat, logic signed [COORD_W-1:0] lon,
                                logic [TAG_W-1:0] tag, logic last);
         longint signed        dlat, dlon, x, y, xs, ys, dist2, lim2;
         logic [ANGLE_W-1:0]   z, zr;
         logic [BEARING_W-1:0] b, left, right;
         logic                 in_sector;
         cone_verdict_type     v;
         dlat  = longint'(lat) - longint'(ctr_lat);
         dlon  = longint'(lon) - longint'(ctr_lon);
         dist2 = dlat * dlat + dlon * dlon;
         lim2  = longint'(range_lim) * longint'(range_lim);
         b     = '0;
         if (dlat != 0 || dlon != 0) begin
            x = dlat;
            y = dlon;
            z = '0;
            if (x < 0) begin
               x = -x;
               y = -y;
               z = 32'h8000_0000;
            end
            for (int i = 0; i < step_count; i++) begin
               xs = x >>> i;
               ys = y >>> i;
               if (y > 0) begin
                  x = x + ys;
                  y = y - xs;
                  z = z + atan_step[i];
               end else begin
                  x = x - ys;
                  y = y + xs;
                  z = z - atan_step[i];
               end
            end
            zr = z + 32'h0000_8000;
            b  = zr[31:16];
         end
         left  = heading - half_width;
         right = heading + half_width;
         if (left <= right) in_sector = (b >= left) && (b <= right);
         else in_sector = (b >= left) || (b <= right);
         if (dist2 > lim2) in_sector = 1'b0;
         v.in_cone = in_sector;
         v.bearing = b;
         v.tag     = tag;
         v.last    = last;
         expected_q = {expected_q, v};
      endfunction

      task report(string field, logic [31:0] got, logic [31:0] want);
         errors++;
         if (errors <= MAX_REPORTS)
            $display("mismatch at result %0d, %s: got 0x%0h, expected 0x%0h",
                     checked, field, got, want);
      endtask

      task check_result(logic in_cone, logic [BEARING_W-1:0] bearing, logic [TAG_W-1:0] tag,
                        logic last);
         cone_verdict_type want;
         if (expected_q.size() == 0) begin
            report("result with no transaction pending, tag", 32'(tag), 32'd0);
            return;
         end
         want = expected_q.pop_front();
         checked++;
         if (want.in_cone) hits++;
         if (in_cone !== want.in_cone) report("in_cone", 32'(in_cone), 32'(want.in_cone));
         if (bearing !== want.bearing) report("bearing", 32'(bearing), 32'(want.bearing));
         if (tag !== want.tag) report("out_tag", 32'(tag), 32'(want.tag));
         if (last !== want.last) report("out_last", 32'(last), 32'(want.last));
      endtask
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [COORD_W-1:0]     req_target_lat = '0;
   logic [COORD_W-1:0]     req_target_lon = '0;
   logic [TAG_W-1:0]       req_target_tag = '0;
   logic                   req_last_target = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_in_cone;
   logic [BEARING_W-1:0]   rsp_bearing;
   logic [TAG_W-1:0]       rsp_out_tag;
   logic                   rsp_out_last;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   cone_scoreboard_type verdicts = new();
   int sent = 0;
   int settings = 0;

   always #5 clock = ~clock;

   radar_cone_gate #(.CORDIC_STEPS(CORDIC_STEPS)) u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_target_lat  (req_target_lat),
      .req_target_lon  (req_target_lon),
      .req_target_tag  (req_target_tag),
      .req_last_target (req_last_target),
      .rsp_valid       (rsp_valid),
      .rsp_in_cone     (rsp_in_cone),
      .rsp_bearing     (rsp_bearing),
      .rsp_out_tag     (rsp_out_tag),
      .rsp_out_last    (rsp_out_last),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         verdicts.check_result(rsp_in_cone, rsp_bearing, rsp_out_tag, rsp_out_last);
   end

   function automatic logic [COORD_W-1:0] shift_coord(input logic [COORD_W-1:0] base,
                                                      input longint signed off);
      return base + off[COORD_W-1:0];
   endfunction

   // leaves start high so the next transaction can follow back to back
   task automatic drive_target(input logic [COORD_W-1:0] lat, input logic [COORD_W-1:0] lon,
                               input logic [TAG_W-1:0] tag, input logic last);
      req_target_lat  <= lat;
      req_target_lon  <= lon;
      req_target_tag  <= tag;
      req_last_target <= last;
      start           <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      verdicts.note_target(lat, lon, tag, last);
      sent++;
   endtask

   task automatic idle_cycles(input int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (verdicts.outstanding() != 0) @(posedge clock);
      repeat (2 * LATENCY) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      verdicts.set_register(idx, data);
   endtask

   task automatic program_cone(input logic [CSR_DATA_W-1:0] lat, input logic [CSR_DATA_W-1:0] lon,
                               input logic [CSR_DATA_W-1:0] head,
                               input logic [CSR_DATA_W-1:0] half,
                               input logic [CSR_DATA_W-1:0] rng, input bit poke_unused);
      write_register(CSR_CENTER_LAT, lat);
      write_register(CSR_CENTER_LON, lon);
      write_register(CSR_HEADING, head);
      write_register(CSR_HALF_ANGLE, half);
      write_register(CSR_RANGE_LIMIT, rng);
      // unmapped indexes must leave every register alone
      if (poke_unused)
         for (int k = int'(CSR_RANGE_LIMIT) + 1; k < (1 << CSR_INDEX_W); k++)
            write_register(CSR_INDEX_W'(k), CSR_DATA_W'($urandom));
      csr_we <= 1'b0;
      settings++;
   endtask

   // mostly targets scattered around the range circle so both verdicts show up
   task automatic pick_target(output logic [COORD_W-1:0] lat, output logic [COORD_W-1:0] lon);
      longint signed bound, dlat, dlon, m;
      int mode;
      bound = longint'(verdicts.range_lim) + (longint'(verdicts.range_lim) >>> 3) + 1;
      mode  = $urandom_range(0, 9);
      dlat  = 0;
      dlon  = 0;
      lat   = COORD_W'($urandom);
      lon   = COORD_W'($urandom);
      if (mode > 2) begin
         if (mode <= 7) begin
            dlat = longint'($urandom_range(0, 32'(2 * bound))) - bound;
            dlon = longint'($urandom_range(0, 32'(2 * bound))) - bound;
         end else if (mode == 8) begin
            dlat = longint'($urandom_range(0, 32)) - 16;
            dlon = longint'($urandom_range(0, 32)) - 16;
         end else begin
            // on an axis or a diagonal
            m = longint'($urandom_range(0, 32'(bound)));
            case ($urandom_range(0, 2))
               0: dlat = m;
               1: dlon = m;
               default: begin
                  dlat = m;
                  dlon = m;
               end
            endcase
            if ($urandom_range(0, 1)) dlat = -dlat;
            if ($urandom_range(0, 1)) dlon = -dlon;
         end
         lat = shift_coord(verdicts.ctr_lat, dlat);
         lon = shift_coord(verdicts.ctr_lon, dlon);
      end
   endtask

   initial begin
      #(TIMEOUT);
      $display("timeout with %0d results outstanding", verdicts.outstanding());
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      logic [COORD_W-1:0]   lat, lon, cfg_lat, cfg_lon, rng;
      logic [BEARING_W-1:0] head, half;
      int burst;
      int gap;
      burst = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset values: zero range, so only the centre itself passes
      drive_target(0, 0, 0, 1'b0);
      drive_target(5, 5, 10'h3FF, 1'b1);
      drive_target(COORD_MIN, COORD_MAX, 10'h001, 1'b0);
      drain();

      // compass points, both cone edges, coordinate extremes
      program_cone(0, 0, 0, 16'd8192, RANGE_MAX, 1'b1);
      drive_target(1000, 0, 10'h010, 1'b0);
      drive_target(0, 1000, 10'h011, 1'b0);
      drive_target(shift_coord(0, -1000), 0, 10'h012, 1'b0);
      drive_target(0, shift_coord(0, -1000), 10'h013, 1'b0);
      drive_target(1000, 1000, 10'h014, 1'b0);
      drive_target(1000, shift_coord(0, -1000), 10'h015, 1'b0);
      drive_target(COORD_MAX, COORD_MAX, 10'h016, 1'b0);
      drive_target(COORD_MIN, COORD_MIN, 10'h017, 1'b0);
      drive_target(COORD_MIN, 0, 10'h018, 1'b1);
      drain();

      // centre in a corner, range boundary hit exactly and missed by one
      program_cone(COORD_MIN, COORD_MAX, 16'hC000, 16'h3000, 1000, 1'b0);
      drive_target(COORD_MIN, COORD_MAX, 10'h020, 1'b0);
      drive_target(COORD_MIN, shift_coord(COORD_MAX, -1000), 10'h021, 1'b0);
      drive_target(COORD_MIN, shift_coord(COORD_MAX, -1001), 10'h022, 1'b0);
      drive_target(shift_coord(COORD_MIN, 600), shift_coord(COORD_MAX, -800), 10'h023, 1'b0);
      drive_target(COORD_MAX, COORD_MIN, 10'h024, 1'b1);
      drain();

      // zero-width cone
      program_cone(COORD_MAX, COORD_MIN, 16'd16384, 0, RANGE_MAX, 1'b0);
      drive_target(COORD_MAX, shift_coord(COORD_MIN, 1000), 10'h030, 1'b0);
      drive_target(COORD_MAX, COORD_MIN, 10'h031, 1'b1);
      drain();

      // half-angle past half a turn: bounds wrap to a narrow gap near zero
      program_cone(0, 0, 0, 16'hFFFF, RANGE_MAX, 1'b0);
      drive_target(0, 0, 10'h040, 1'b0);
      drive_target(1000, 0, 10'h041, 1'b0);
      drive_target(0, 1000, 10'h042, 1'b1);
      drain();

      for (int p = 0; p < RANDOM_SETS; p++) begin
         cfg_lat = COORD_W'($urandom);
         cfg_lon = COORD_W'($urandom);
         head    = BEARING_W'($urandom);
         case ($urandom_range(0, 4))
            0: half = '0;
            1: half = 16'hFFFF;
            2: half = 16'h8000;
            3: half = BEARING_W'($urandom_range(0, 16384));
            default: half = BEARING_W'($urandom);
         endcase
         case ($urandom_range(0, 5))
            0: rng = '0;
            1: rng = RANGE_MAX;
            default: rng = COORD_W'($urandom) >> $urandom_range(0, 28);
         endcase
         // junk above the angle fields must be dropped
         program_cone(cfg_lat, cfg_lon, {13'($urandom), head}, {13'($urandom), half}, rng,
                      $urandom_range(0, 1));
         for (int n = 0; n < SET_ITEMS; n++) begin
            pick_target(lat, lon);
            drive_target(lat, lon, TAG_W'($urandom), ($urandom_range(0, 7) == 0));
            if (p == 3 && n == SET_ITEMS / 2) begin
               drain();
            end else if (p % 3 != 0) begin
               if (burst == 0) begin
                  burst = $urandom_range(1, 24);
                  gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 4);
                  idle_cycles(gap);
               end
               burst--;
            end
         end
         drain();
      end

      $display("%0d targets over %0d cone settings, %0d results checked, %0d inside the cone",
               sent, settings, verdicts.checked, verdicts.hits);
      if (verdicts.errors == 0 && verdicts.outstanding() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches", verdicts.errors);
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
